### design/range_flip_bit_array_defines.svh
// Assertion macros for the range flip bit array.
// Included by the top level; the checks compile away when SYNTHESIS is defined.
`ifndef RANGE_FLIP_BIT_ARRAY_DEFINES_SVH
`define RANGE_FLIP_BIT_ARRAY_DEFINES_SVH
`ifndef SYNTHESIS
`define RFBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rfba property failed");
`define RFBA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rfba forbidden condition seen");
`else
`define RFBA_ASSERT(lbl, clk, rst_n, prop)
`define RFBA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### design/rfba_pkg.sv
// Shared types and constants of the range flip bit array.
// Used by rfba_cell and range_flip_bit_array; depends on nothing else.
`timescale 1ns / 1ps

package rfba_pkg;

    localparam int POS_W  = 11;  // width of positions and of the length register
    localparam int NODE_W = 22;  // tree node numbers for trees of up to 4M nodes
    localparam int CANDS  = 4;   // nodes carried per level by one transfer

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_INVERT = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  range_end;
        logic              load_value;
    } t_item;

    typedef struct packed {
        logic bit_value;
        logic bad_position;
    } t_result;

    // One tree node with the interval it covers.
    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } t_cand;

    // Work that moves from one level cell to the next.
    typedef struct packed {
        logic                  vld;
        t_kind                 kind;
        logic [POS_W-1:0]      position;
        logic [POS_W-1:0]      range_end;
        logic                  parity;
        t_cand [CANDS-1:0]     cand;
    } t_tok;

endpackage

### design/rfba_cell.sv
// One tree level of the flip parity store: the level's parity memory and the
// logic that classifies its nodes. Depends on rfba_pkg.
`timescale 1ns / 1ps

module rfba_cell #(
    parameter int LEVEL      = 0,
    parameter int TREE_NODES = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfba_pkg::t_tok i_tok,
    input  logic           i_clear,
    output rfba_pkg::t_tok o_tok,
    output logic           o_busy
);

    localparam int DEPTH = 1 << LEVEL;
    localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
    localparam int SW    = $clog2(rfba_pkg::CANDS + 1);
    localparam int CW    = $clog2(rfba_pkg::CANDS);

    logic                   r_mem [DEPTH];
    logic                   r_rdata;
    rfba_pkg::t_tok         r_tok;
    logic                   r_vld;
    logic                   r_run;
    logic [SW-1:0]          r_step;
    logic                   r_sweep;
    logic [AW-1:0]          r_sw_addr;

    logic [rfba_pkg::CANDS-1:0] ok;
    logic [rfba_pkg::CANDS-1:0] cov;
    logic [rfba_pkg::CANDS-1:0] part;
    logic [rfba_pkg::POS_W-1:0] mid [rfba_pkg::CANDS];

    logic [CW-1:0]  rd_sel;
    logic [CW-1:0]  wr_sel;
    logic           q_rd;
    logic [AW-1:0]  raddr;
    logic           we;
    logic [AW-1:0]  waddr;
    logic           wdata;

    function automatic logic [AW-1:0] addr_of(input logic [rfba_pkg::NODE_W-1:0] node);
        if (LEVEL == 0) begin
            return '0;
        end
        return node[AW-1:0];
    endfunction

    // Classify each node carried to this level against the inverted range.
    always_comb begin
        logic disj;
        for (int k = 0; k < rfba_pkg::CANDS; k++) begin
            ok[k]   = r_tok.cand[k].vld && (int'(r_tok.cand[k].node) < TREE_NODES);
            disj    = (r_tok.range_end < r_tok.cand[k].lo) ||
                      (r_tok.position > r_tok.cand[k].hi);
            cov[k]  = ok[k] && !disj && (r_tok.position <= r_tok.cand[k].lo) &&
                      (r_tok.cand[k].hi <= r_tok.range_end);
            part[k] = ok[k] && !disj && !cov[k];
            mid[k]  = rfba_pkg::POS_W'(({1'b0, r_tok.cand[k].lo} +
                                        {1'b0, r_tok.cand[k].hi}) >> 1);
        end
    end

    // Hand the next level its nodes in the cycle after arrival.
    always_comb begin
        logic [1:0] j;
        o_tok     = r_tok;
        o_tok.vld = r_vld;
        j         = 2'd0;
        for (int k = 0; k < rfba_pkg::CANDS; k++) begin
            o_tok.cand[k].vld = 1'b0;
        end
        if (r_tok.kind == rfba_pkg::KIND_INVERT) begin
            for (int k = 0; k < rfba_pkg::CANDS; k++) begin
                if (part[k] && (j != 2'd2)) begin
                    o_tok.cand[2*j].vld    = 1'b1;
                    o_tok.cand[2*j].node   = {r_tok.cand[k].node[rfba_pkg::NODE_W-2:0], 1'b0};
                    o_tok.cand[2*j].lo     = r_tok.cand[k].lo;
                    o_tok.cand[2*j].hi     = mid[k];
                    o_tok.cand[2*j+1].vld  = 1'b1;
                    o_tok.cand[2*j+1].node = {r_tok.cand[k].node[rfba_pkg::NODE_W-2:0], 1'b1};
                    o_tok.cand[2*j+1].lo   = mid[k] + rfba_pkg::POS_W'(1);
                    o_tok.cand[2*j+1].hi   = r_tok.cand[k].hi;
                    j = j + 2'd1;
                end
            end
        end else begin
            o_tok.parity = r_tok.parity ^ (ok[0] & r_rdata);
            if (ok[0] && (r_tok.cand[0].lo < r_tok.cand[0].hi)) begin
                o_tok.cand[0].vld = 1'b1;
                if (r_tok.position <= mid[0]) begin
                    o_tok.cand[0].node = {r_tok.cand[0].node[rfba_pkg::NODE_W-2:0], 1'b0};
                    o_tok.cand[0].hi   = mid[0];
                end else begin
                    o_tok.cand[0].node = {r_tok.cand[0].node[rfba_pkg::NODE_W-2:0], 1'b1};
                    o_tok.cand[0].lo   = mid[0] + rfba_pkg::POS_W'(1);
                end
            end
        end
    end

    // A query reads at arrival so its parity is ready when the transfer moves on.
    // An invert toggles its covered nodes one per cycle, reads running one step
    // ahead of writes.
    assign rd_sel = r_step[CW-1:0];
    assign wr_sel = r_step[CW-1:0] - CW'(1);
    assign q_rd   = i_tok.vld && (i_tok.kind == rfba_pkg::KIND_QUERY);
    assign raddr  = q_rd ? addr_of(i_tok.cand[0].node) : addr_of(r_tok.cand[rd_sel].node);

    always_comb begin
        we    = 1'b0;
        waddr = addr_of(r_tok.cand[wr_sel].node);
        wdata = ~r_rdata;
        if (r_sweep) begin
            we    = 1'b1;
            waddr = r_sw_addr;
            wdata = 1'b0;
        end else if (r_run && (r_step != '0) && cov[wr_sel]) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
        if (i_tok.vld) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_run     <= 1'b0;
            r_step    <= '0;
            r_sweep   <= 1'b1;
            r_sw_addr <= '0;
        end else begin
            r_vld <= i_tok.vld;
            if (r_vld && (r_tok.kind == rfba_pkg::KIND_INVERT)) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                if (r_step == SW'(rfba_pkg::CANDS)) begin
                    r_run <= 1'b0;
                end
                r_step <= r_step + SW'(1);
            end
            if (i_clear) begin
                r_sweep   <= 1'b1;
                r_sw_addr <= '0;
            end else if (r_sweep) begin
                if (r_sw_addr == AW'(DEPTH - 1)) begin
                    r_sweep <= 1'b0;
                end
                r_sw_addr <= r_sw_addr + AW'(1);
            end
        end
    end

    assign o_busy = r_vld | r_run | r_sweep;

endmodule

### design/range_flip_bit_array.sv
// Top level of the range flip bit array: loaded bits, length register and the
// chain of tree level cells. Depends on rfba_pkg, rfba_cell and the defines header.
`timescale 1ns / 1ps
`include "range_flip_bit_array_defines.svh"

// Bit array with range inversion and point reads. A load never raises busy.
// A query walks the tree one level per cycle down the cell chain and
// delivers its result through a register behind the last cell, with busy
// low again when the result appears; a query outside the active length
// answers in the next cycle. An invert passes down the chain the same way,
// and each level then toggles up to four of its nodes, so busy stays high
// until the last level has finished. A clear, and reset, run a clearing
// pass over every level memory: busy stays high until the largest one is
// cleared. Results appear on o_result for one cycle with o_result_valid
// and cannot be held off by the receiver.
// Configuration writes are always taken.
module range_flip_bit_array #(
    parameter int MAX_BITS   = 1024,
    parameter int TREE_NODES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rfba_pkg::t_item            i_item,
    output logic                       o_result_valid,
    output rfba_pkg::t_result          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rfba_pkg::POS_W-1:0] i_cfg_data
);

    localparam int LVL_BITS = $clog2(MAX_BITS) + 1;
    localparam int LVL_TREE = $clog2(TREE_NODES);
    localparam int LEVELS   = (LVL_BITS < LVL_TREE) ? LVL_BITS : LVL_TREE;
    localparam int BA       = $clog2(MAX_BITS);

    logic                       r_bits [MAX_BITS];
    logic                       r_bit;
    logic [rfba_pkg::POS_W-1:0] r_len;
    logic                       r_res_vld;
    rfba_pkg::t_result          r_res;

    logic [rfba_pkg::POS_W-1:0] w_len;
    logic                       w_acc;
    logic                       w_load;
    logic                       w_q_ok;
    logic                       w_q_bad;
    logic                       w_inv;
    logic                       w_clear;
    logic                       w_res;
    logic [BA-1:0]              w_baddr;
    logic [LEVELS-1:0]          w_busy;
    rfba_pkg::t_tok             w_tok [LEVELS+1];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_len == '0) begin
            w_len = rfba_pkg::POS_W'(1);
        end else if (int'(r_len) > MAX_BITS) begin
            w_len = rfba_pkg::POS_W'(MAX_BITS);
        end else begin
            w_len = r_len;
        end
    end

    assign w_acc   = start && !busy;
    assign w_baddr = BA'(i_item.position - rfba_pkg::POS_W'(1));
    assign w_load  = w_acc && (i_item.kind == rfba_pkg::KIND_LOAD) &&
                     (i_item.position != '0) && (int'(i_item.position) <= MAX_BITS);
    assign w_q_ok  = w_acc && (i_item.kind == rfba_pkg::KIND_QUERY) &&
                     (i_item.position != '0) && (i_item.position <= w_len);
    assign w_q_bad = w_acc && (i_item.kind == rfba_pkg::KIND_QUERY) && !w_q_ok;
    assign w_inv   = w_acc && (i_item.kind == rfba_pkg::KIND_INVERT) &&
                     (i_item.position <= i_item.range_end);
    assign w_clear = w_acc && (i_item.kind == rfba_pkg::KIND_CLEAR);

    // The root node covers the whole active length.
    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].vld       = w_inv || w_q_ok;
        w_tok[0].kind      = i_item.kind;
        w_tok[0].position  = i_item.position;
        w_tok[0].range_end = i_item.range_end;
        w_tok[0].cand[0].vld  = 1'b1;
        w_tok[0].cand[0].node = rfba_pkg::NODE_W'(1);
        w_tok[0].cand[0].lo   = rfba_pkg::POS_W'(1);
        w_tok[0].cand[0].hi   = w_len;
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        rfba_cell #(
            .LEVEL      (g),
            .TREE_NODES (TREE_NODES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_clear (w_clear),
            .o_tok   (w_tok[g+1]),
            .o_busy  (w_busy[g])
        );
    end

    assign busy  = |w_busy;
    assign w_res = w_tok[LEVELS].vld && (w_tok[LEVELS].kind == rfba_pkg::KIND_QUERY);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bits[w_baddr] <= i_item.load_value;
        end
        if (w_q_ok) begin
            r_bit <= r_bits[w_baddr];
        end
        if (w_res) begin
            r_res.bit_value    <= r_bit ^ w_tok[LEVELS].parity;
            r_res.bad_position <= 1'b0;
        end else if (w_q_bad) begin
            r_res.bit_value    <= 1'b0;
            r_res.bad_position <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= rfba_pkg::POS_W'(1);
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
            r_res_vld <= w_res || w_q_bad;
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    `RFBA_ASSERT(a_clear_busy, i_clk, i_rst_n, w_clear |=> busy)
    `RFBA_ASSERT(a_launch_busy, i_clk, i_rst_n, w_tok[0].vld |=> busy)
    `RFBA_ASSERT(a_chain_result, i_clk, i_rst_n, o_result_valid && !o_result.bad_position |-> $past(busy))
    `RFBA_ASSERT_NEVER(a_bad_zero, i_clk, i_rst_n, o_result_valid && o_result.bad_position && o_result.bit_value)

endmodule

### bench/tb_range_flip_bit_array.sv
// Testbench for range_flip_bit_array: sends load, invert, query and clear items
// and checks every query result against a flip-parity tree kept in the bench.
// Depends on rfba_pkg and the range_flip_bit_array RTL.
`timescale 1ns / 1ps

module tb_range_flip_bit_array;

    localparam int MAX_BITS    = 1024;
    localparam int TREE_NODES  = 4096;
    localparam int SETTLE_CYC  = 1100;  // longer than the clearing pass of a clear item
    localparam int STALL_LIMIT = 20000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    rfba_pkg::t_item            i_item = '0;
    logic                       o_result_valid;
    rfba_pkg::t_result          o_result;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [rfba_pkg::POS_W-1:0] i_cfg_data = '0;

    // Bench copy of the block state.
    logic                       flip_mark [TREE_NODES];
    logic                       seed_bit  [MAX_BITS];
    logic                       seed_set  [MAX_BITS];
    logic [rfba_pkg::POS_W-1:0] length_reg;
    rfba_pkg::t_result          reads_due [$];

    int  n_errors = 0;
    int  n_items = 0;
    int  n_reads = 0;
    int  n_checked = 0;
    int  n_lengths = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;

    range_flip_bit_array #(
        .MAX_BITS   (MAX_BITS),
        .TREE_NODES (TREE_NODES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int used_length();
        if (length_reg == '0) return 1;
        if (int'(length_reg) > MAX_BITS) return MAX_BITS;
        return int'(length_reg);
    endfunction

    function automatic void toggle_span(int node, int lo, int hi, int a, int b);
        int mid;
        if (b < lo || a > hi || node >= TREE_NODES) return;
        if (a <= lo && hi <= b) begin
            flip_mark[node] = ~flip_mark[node];
            return;
        end
        mid = (lo + hi) >> 1;
        toggle_span(2 * node, lo, mid, a, b);
        toggle_span(2 * node + 1, mid + 1, hi, a, b);
    endfunction

    function automatic logic path_flips(int pos, int len);
        int   node;
        int   lo;
        int   hi;
        int   mid;
        logic par;
        node = 1;
        lo   = 1;
        hi   = len;
        par  = flip_mark[1];
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (pos <= mid) begin
                node = 2 * node;
                hi   = mid;
            end else begin
                node = 2 * node + 1;
                lo   = mid + 1;
            end
            if (node >= TREE_NODES) break;
            par ^= flip_mark[node];
        end
        return par;
    endfunction

    function automatic void apply_item(rfba_pkg::t_item it);
        int                len;
        int                pos;
        int                last;
        rfba_pkg::t_result r;
        len  = used_length();
        pos  = int'(it.position);
        last = int'(it.range_end);
        case (it.kind)
            rfba_pkg::KIND_LOAD: begin
                if (pos >= 1 && pos <= MAX_BITS) begin
                    seed_bit[pos-1] = it.load_value;
                    seed_set[pos-1] = 1'b1;
                end
            end
            rfba_pkg::KIND_INVERT: begin
                if (pos <= last) toggle_span(1, 1, len, pos, last);
            end
            rfba_pkg::KIND_CLEAR: begin
                foreach (flip_mark[k]) flip_mark[k] = 1'b0;
            end
            default: begin
                if (pos < 1 || pos > len) begin
                    r.bit_value    = 1'b0;
                    r.bad_position = 1'b1;
                end else begin
                    r.bit_value    = seed_bit[pos-1] ^ path_flips(pos, len);
                    r.bad_position = 1'b0;
                end
                reads_due.push_back(r);
                n_reads++;
            end
        endcase
    endfunction

    // Mostly well-formed traffic inside the active length, with some noise.
    // A query of a bit never loaded is turned into a load of that bit.
    function automatic rfba_pkg::t_item random_item();
        rfba_pkg::t_item it;
        int              len;
        int              roll;
        int              a;
        len           = used_length();
        roll          = int'($urandom_range(0, 99));
        it.load_value = 1'($urandom_range(0, 1));
        it.range_end  = rfba_pkg::POS_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 99) < 85) it.position = rfba_pkg::POS_W'($urandom_range(1, len));
        else it.position = rfba_pkg::POS_W'($urandom_range(0, 2047));
        if (roll < 2) begin
            it.kind = rfba_pkg::KIND_CLEAR;
        end else if (roll < 27) begin
            it.kind = rfba_pkg::KIND_LOAD;
        end else if (roll < 55) begin
            it.kind = rfba_pkg::KIND_INVERT;
            if ($urandom_range(0, 99) < 85) begin
                a            = int'($urandom_range(1, len));
                it.position  = rfba_pkg::POS_W'(a);
                it.range_end = rfba_pkg::POS_W'($urandom_range(a, len));
            end
        end else begin
            it.kind = rfba_pkg::KIND_QUERY;
            if (it.position >= 1 && int'(it.position) <= len && !seed_set[it.position-1])
                it.kind = rfba_pkg::KIND_LOAD;
        end
        return it;
    endfunction

    // Leaves start high after the transfer so back-to-back items need no toggle.
    task automatic send_item(input rfba_pkg::t_item it);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1)) begin
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_item(it);
        n_items++;
    endtask

    task automatic issue(input rfba_pkg::t_kind k, input int pos, input int last,
                         input bit val);
        rfba_pkg::t_item it;
        it.kind       = k;
        it.position   = rfba_pkg::POS_W'(pos);
        it.range_end  = rfba_pkg::POS_W'(last);
        it.load_value = val;
        send_item(it);
    endtask

    task automatic settle();
        while (reads_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [rfba_pkg::POS_W-1:0] value);
        start <= 1'b0;
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        length_reg = value;
        n_lengths++;
    endtask

    task automatic run_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            send_item(random_item());
        end
    endtask

    task automatic test_reset_length();
        run_traffic(60);
    endtask

    task automatic test_directed_edges();
        write_length(11'd1024);
        issue(rfba_pkg::KIND_LOAD, 1, 0, 1'b1);
        issue(rfba_pkg::KIND_LOAD, 1024, 0, 1'b0);
        issue(rfba_pkg::KIND_LOAD, 512, 2047, 1'b1);
        // Loads at position zero or beyond the array are dropped.
        issue(rfba_pkg::KIND_LOAD, 0, 0, 1'b1);
        issue(rfba_pkg::KIND_LOAD, 2047, 0, 1'b1);
        issue(rfba_pkg::KIND_LOAD, 1025, 0, 1'b1);
        issue(rfba_pkg::KIND_QUERY, 1, 0, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 1024, 0, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 512, 0, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 0, 0, 1'b1);
        issue(rfba_pkg::KIND_QUERY, 1025, 2047, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 2047, 0, 1'b0);
        issue(rfba_pkg::KIND_INVERT, 1, 1024, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 1, 0, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 1024, 0, 1'b0);
        issue(rfba_pkg::KIND_INVERT, 600, 300, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 512, 0, 1'b0);
        issue(rfba_pkg::KIND_INVERT, 1000, 2047, 1'b1);
        issue(rfba_pkg::KIND_QUERY, 1024, 0, 1'b0);
        issue(rfba_pkg::KIND_INVERT, 512, 512, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 512, 0, 1'b0);
        issue(rfba_pkg::KIND_CLEAR, 0, 0, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 1, 0, 1'b0);
        issue(rfba_pkg::KIND_QUERY, 1024, 0, 1'b0);
    endtask

    // Lengths above the array size and zero are both clamped by the block.
    task automatic test_length_limits();
        write_length(11'd2047);
        issue(rfba_pkg::KIND_CLEAR, 0, 0, 1'b0);
        run_traffic(80);
        write_length(11'd0);
        run_traffic(80);
    endtask

    // Marks left by inverts at one length stay in place when the length changes.
    task automatic test_length_change_keeps_marks();
        write_length(11'd1024);
        for (int i = 0; i < 10; i++)
            issue(rfba_pkg::KIND_INVERT, int'($urandom_range(1, 700)),
                  int'($urandom_range(300, 1024)), 1'b0);
        write_length(11'd37);
        run_traffic(90);
    endtask

    task automatic test_random_lengths();
        int lengths [5];
        lengths = '{2, 513, 1000, int'($urandom_range(3, 1023)), int'($urandom_range(3, 1023))};
        foreach (lengths[i]) begin
            write_length(rfba_pkg::POS_W'(lengths[i]));
            if ($urandom_range(0, 1)) issue(rfba_pkg::KIND_CLEAR, 0, 0, 1'b0);
            run_traffic(90);
        end
    endtask

    always @(posedge i_clk) begin
        rfba_pkg::t_result want;
        if (i_rst_n && o_result_valid) begin
            if (reads_due.size() == 0) begin
                $error("unexpected result: bit_value %0b bad_position %0b",
                       o_result.bit_value, o_result.bad_position);
                n_errors++;
            end else begin
                want = reads_due.pop_front();
                n_checked++;
                if (o_result.bit_value !== want.bit_value) begin
                    $error("bit_value: expected %0b, got %0b",
                           want.bit_value, o_result.bit_value);
                    n_errors++;
                end
                if (o_result.bad_position !== want.bad_position) begin
                    $error("bad_position: expected %0b, got %0b",
                           want.bad_position, o_result.bad_position);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", idle_cycles);
            $display("range_flip_bit_array test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (flip_mark[k]) flip_mark[k] = 1'b0;
        foreach (seed_bit[k]) begin
            seed_bit[k] = 1'b0;
            seed_set[k] = 1'b0;
        end
        length_reg = 11'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its tree after reset before it takes any item.
        settle();
        test_reset_length();
        test_directed_edges();
        test_length_limits();
        test_length_change_keeps_marks();
        test_random_lengths();
        start <= 1'b0;
        settle();
        $display("Sent %0d items under %0d length settings; checked %0d of %0d bit reads.",
                 n_items, n_lengths, n_checked, n_reads);
        if (n_errors == 0) begin
            $display("range_flip_bit_array test passed");
        end else begin
            $display("range_flip_bit_array test failed");
        end
        $finish;
    end

endmodule
